// ===== rtl/core/tilt_kalman_filter_defines.svh =====
// assertion macros for the tilt kalman filter checker
`ifndef TILT_KALMAN_FILTER_DEFINES_SVH
`define TILT_KALMAN_FILTER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define TKF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define TKF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/tkf_pkg.sv =====
// shared types and constants of the tilt kalman filter
package tkf_pkg;

   localparam int CSR_IDX_WIDTH = 3;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SAMPLE_PERIOD = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ANGLE_NOISE   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BIAS_NOISE    = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MEASURE_NOISE = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ZERO_OFFSET   = 3'd4;

   // register reset values, q28 encoded
   localparam logic [63:0] RST_SAMPLE_PERIOD = 64'd13421773;
   localparam logic [63:0] RST_ANGLE_NOISE   = 64'd268435;
   localparam logic [63:0] RST_BIAS_NOISE    = 64'd805306;
   localparam logic [63:0] RST_MEASURE_NOISE = 64'd134217728;
   localparam logic [63:0] RST_ZERO_OFFSET   = 64'd6442451;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } tkf_op_type;

   typedef struct packed {
      logic       start;
      tkf_op_type op;
   } tkf_cmd_type;

endpackage

// ===== rtl/core/tkf_muldiv.sv =====
// shared sequential fixed point multiply / divide unit with saturation
module tkf_muldiv #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 28
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tkf_pkg::tkf_cmd_type         cmd,
   input  logic signed [DATA_WIDTH-1:0] opa,
   input  logic signed [DATA_WIDTH-1:0] opb,
   output logic                         done,
   output logic signed [DATA_WIDTH-1:0] result
);
   import tkf_pkg::*;

   localparam int DIGITS    = (DATA_WIDTH + 15) / 16;
   localparam int LOW_W     = DIGITS * 16;
   localparam int PROD_W    = DATA_WIDTH + LOW_W;
   localparam int NUM_W     = DATA_WIDTH + FRAC_BITS;
   localparam int DIV_STEPS = DATA_WIDTH + FRAC_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   localparam logic [1:0] U_IDLE = 2'd0;
   localparam logic [1:0] U_MUL  = 2'd1;
   localparam logic [1:0] U_DIV  = 2'd2;
   localparam logic [1:0] U_FIN  = 2'd3;

   localparam logic [PROD_W-1:0] POS_LIM = PROD_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
   localparam logic [PROD_W-1:0] NEG_LIM = PROD_W'({1'b1, {(DATA_WIDTH-1){1'b0}}});
   localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic [1:0]             state_ff, state_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic                   is_div_ff, is_div_in;
   logic [DATA_WIDTH-1:0]  mcand_ff, mcand_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [NUM_W-1:0]       num_ff, num_in;
   logic [DATA_WIDTH-1:0]  den_ff, den_in;
   logic [DATA_WIDTH-1:0]  rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]  quo_ff, quo_in;
   logic                   over_ff, over_in;
   logic signed [DATA_WIDTH-1:0] result_ff, result_in;

   logic [DATA_WIDTH+15:0] pp_sum;
   logic [DATA_WIDTH:0]    rem_shift;
   logic                   rem_ge;
   logic [DATA_WIDTH:0]    rem_diff;
   logic [PROD_W-1:0]      mag_wide;
   logic [DATA_WIDTH-1:0]  sat_val;

   function automatic logic [DATA_WIDTH-1:0] magnitude(input logic [DATA_WIDTH-1:0] v);
      logic [DATA_WIDTH-1:0] m;
      m = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
      return m;
   endfunction

   // one 16-bit digit of the multiplier per cycle, running high half
   assign pp_sum = (DATA_WIDTH + 16)'(mcand_ff) * (DATA_WIDTH + 16)'(prod_ff[15:0])
                 + (DATA_WIDTH + 16)'(prod_ff[PROD_W-1 -: DATA_WIDTH]);

   // restoring division, one quotient bit per cycle
   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, den_ff};
   assign rem_diff  = rem_shift - {1'b0, den_ff};

   always_comb begin
      mag_wide = is_div_ff ? PROD_W'({over_ff, quo_ff}) : (prod_ff >> FRAC_BITS);
      if (neg_ff) begin
         sat_val = (mag_wide > NEG_LIM) ? SAT_MIN : (~mag_wide[DATA_WIDTH-1:0] + 1'b1);
      end else begin
         sat_val = (mag_wide > POS_LIM) ? SAT_MAX : mag_wide[DATA_WIDTH-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      is_div_in = is_div_ff;
      mcand_in  = mcand_ff;
      prod_in   = prod_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      over_in   = over_ff;
      result_in = result_ff;
      case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               cnt_in = '0;
               if (cmd.op == OP_DIV) begin
                  is_div_in = 1'b1;
                  neg_in    = opa[DATA_WIDTH-1];
                  num_in    = {magnitude(opa), {FRAC_BITS{1'b0}}};
                  den_in    = opb;
                  rem_in    = '0;
                  quo_in    = '0;
                  over_in   = 1'b0;
                  state_in  = U_DIV;
               end else begin
                  is_div_in = 1'b0;
                  neg_in    = opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
                  mcand_in  = magnitude(opa);
                  prod_in   = {{DATA_WIDTH{1'b0}}, LOW_W'(magnitude(opb))};
                  state_in  = U_MUL;
               end
            end
         end
         U_MUL: begin
            prod_in = {pp_sum, prod_ff[LOW_W-1:16]};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIGITS - 1)) begin
               state_in = U_FIN;
            end
         end
         U_DIV: begin
            num_in  = num_ff << 1;
            rem_in  = rem_ge ? rem_diff[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
            over_in = over_ff | quo_ff[DATA_WIDTH-1];
            quo_in  = {quo_ff[DATA_WIDTH-2:0], rem_ge};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = U_FIN;
            end
         end
         U_FIN: begin
            result_in = sat_val;
            done_in   = 1'b1;
            state_in  = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      is_div_ff <= is_div_in;
      mcand_ff  <= mcand_in;
      prod_ff   <= prod_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      over_ff   <= over_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== rtl/core/tilt_kalman_filter.sv =====
// tilt kalman filter top level: register file, step sequencer and shared unit
// Two-state (angle, gyro bias) Kalman filter. One request is an accelerometer
// angle and a gyro angle change; one response is the filtered angle minus the
// zero offset, all signed fixed point with FRAC_BITS fraction bits, saturating.
// The single shared multiply/divide unit performs ten multiplies and two
// restoring divisions per request, the divisions at one quotient bit per
// cycle. When the innovation variance is not positive the divisions are
// skipped. The next request is accepted once the previous one is finished,
// even while its response still waits in the output register. Registers
// must be written only while no request is in flight; the block itself
// does not enforce this.
module tilt_kalman_filter #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 28
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [DATA_WIDTH-1:0]     req_accel_angle,
   input  logic signed [DATA_WIDTH-1:0]     req_gyro_delta,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [DATA_WIDTH-1:0]     rsp_tilt_angle,
   input  logic                             csr_wr_en,
   input  logic [tkf_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]            csr_wdata
);
   import tkf_pkg::*;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_P_MB = 5'd1;
   localparam logic [4:0] S_P_SG = 5'd2;
   localparam logic [4:0] S_P_AA = 5'd3;
   localparam logic [4:0] S_P_D0 = 5'd4;
   localparam logic [4:0] S_P_D1 = 5'd5;
   localparam logic [4:0] S_P_MD = 5'd6;
   localparam logic [4:0] S_P_CA = 5'd7;
   localparam logic [4:0] S_P_NG = 5'd8;
   localparam logic [4:0] S_P_MN = 5'd9;
   localparam logic [4:0] S_P_CB = 5'd10;
   localparam logic [4:0] S_P_CC = 5'd11;
   localparam logic [4:0] S_P_MQ = 5'd12;
   localparam logic [4:0] S_P_CD = 5'd13;
   localparam logic [4:0] S_U_ER = 5'd14;
   localparam logic [4:0] S_U_E  = 5'd15;
   localparam logic [4:0] S_U_K0 = 5'd16;
   localparam logic [4:0] S_U_K1 = 5'd17;
   localparam logic [4:0] S_U_M0 = 5'd18;
   localparam logic [4:0] S_U_S0 = 5'd19;
   localparam logic [4:0] S_U_M1 = 5'd20;
   localparam logic [4:0] S_U_S1 = 5'd21;
   localparam logic [4:0] S_U_M2 = 5'd22;
   localparam logic [4:0] S_U_S2 = 5'd23;
   localparam logic [4:0] S_U_M3 = 5'd24;
   localparam logic [4:0] S_U_S3 = 5'd25;
   localparam logic [4:0] S_U_M4 = 5'd26;
   localparam logic [4:0] S_U_S4 = 5'd27;
   localparam logic [4:0] S_U_M5 = 5'd28;
   localparam logic [4:0] S_U_S5 = 5'd29;
   localparam logic [4:0] S_OUT  = 5'd30;

   localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [DATA_WIDTH-1:0] COV_ONE =
      (FRAC_BITS <= DATA_WIDTH - 2) ? (DATA_WIDTH'(1) << FRAC_BITS) : SAT_MAX;

   logic [4:0] state_ff, state_in;

   // filter state
   logic signed [DATA_WIDTH-1:0] angle_ff, angle_in;
   logic signed [DATA_WIDTH-1:0] bias_ff, bias_in;
   logic signed [DATA_WIDTH-1:0] cov_aa_ff, cov_aa_in;
   logic signed [DATA_WIDTH-1:0] cov_ab_ff, cov_ab_in;
   logic signed [DATA_WIDTH-1:0] cov_ba_ff, cov_ba_in;
   logic signed [DATA_WIDTH-1:0] cov_bb_ff, cov_bb_in;

   // working registers
   logic signed [DATA_WIDTH-1:0] accel_ff, accel_in;
   logic signed [DATA_WIDTH-1:0] gyro_ff, gyro_in;
   logic signed [DATA_WIDTH-1:0] tmp_ff, tmp_in;
   logic signed [DATA_WIDTH-1:0] err_ff, err_in;
   logic signed [DATA_WIDTH-1:0] innov_ff, innov_in;
   logic signed [DATA_WIDTH-1:0] gain0_ff, gain0_in;
   logic signed [DATA_WIDTH-1:0] gain1_ff, gain1_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                         issued_ff, issued_in;

   // configuration
   logic [FRAC_BITS-1:0]         sample_period_ff, sample_period_in;
   logic [DATA_WIDTH-2:0]        angle_noise_ff, angle_noise_in;
   logic [DATA_WIDTH-2:0]        bias_noise_ff, bias_noise_in;
   logic [DATA_WIDTH-2:0]        measure_noise_ff, measure_noise_in;
   logic signed [DATA_WIDTH-1:0] zero_offset_ff, zero_offset_in;

   logic signed [DATA_WIDTH-1:0] dt_ext, qa_ext, qb_ext, rm_ext;
   logic                         innov_pos;

   logic signed [DATA_WIDTH-1:0] add_a, add_b, add_res;
   logic                         add_sub;
   logic [DATA_WIDTH:0]          add_wide;

   logic signed [DATA_WIDTH-1:0] unit_a, unit_b, unit_result;
   logic                         unit_go, unit_start, unit_done;
   tkf_op_type                   unit_op;
   tkf_cmd_type                  unit_cmd;

   assign dt_ext    = DATA_WIDTH'(sample_period_ff);
   assign qa_ext    = {1'b0, angle_noise_ff};
   assign qb_ext    = {1'b0, bias_noise_ff};
   assign rm_ext    = {1'b0, measure_noise_ff};
   assign innov_pos = !innov_ff[DATA_WIDTH-1] && (innov_ff != '0);

   // saturating add / subtract, one per cycle
   always_comb begin
      if (add_sub) begin
         add_wide = {add_a[DATA_WIDTH-1], add_a} - {add_b[DATA_WIDTH-1], add_b};
      end else begin
         add_wide = {add_a[DATA_WIDTH-1], add_a} + {add_b[DATA_WIDTH-1], add_b};
      end
      if (add_wide[DATA_WIDTH] != add_wide[DATA_WIDTH-1]) begin
         add_res = add_wide[DATA_WIDTH] ? SAT_MIN : SAT_MAX;
      end else begin
         add_res = add_wide[DATA_WIDTH-1:0];
      end
   end

   assign unit_start = unit_go && !issued_ff;
   assign unit_cmd   = '{start: unit_start, op: unit_op};
   assign issued_in  = unit_done ? 1'b0 : (unit_start ? 1'b1 : issued_ff);

   tkf_muldiv #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (unit_cmd),
      .opa   (unit_a),
      .opb   (unit_b),
      .done  (unit_done),
      .result(unit_result)
   );

   always_comb begin
      sample_period_in = sample_period_ff;
      angle_noise_in   = angle_noise_ff;
      bias_noise_in    = bias_noise_ff;
      measure_noise_in = measure_noise_ff;
      zero_offset_in   = zero_offset_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SAMPLE_PERIOD: sample_period_in = FRAC_BITS'(csr_wdata);
            CSR_ANGLE_NOISE:   angle_noise_in   = csr_wdata[DATA_WIDTH-2:0];
            CSR_BIAS_NOISE:    bias_noise_in    = csr_wdata[DATA_WIDTH-2:0];
            CSR_MEASURE_NOISE: measure_noise_in = csr_wdata[DATA_WIDTH-2:0];
            CSR_ZERO_OFFSET:   zero_offset_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // step sequencer
   always_comb begin
      state_in     = state_ff;
      angle_in     = angle_ff;
      bias_in      = bias_ff;
      cov_aa_in    = cov_aa_ff;
      cov_ab_in    = cov_ab_ff;
      cov_ba_in    = cov_ba_ff;
      cov_bb_in    = cov_bb_ff;
      accel_in     = accel_ff;
      gyro_in      = gyro_ff;
      tmp_in       = tmp_ff;
      err_in       = err_ff;
      innov_in     = innov_ff;
      gain0_in     = gain0_ff;
      gain1_in     = gain1_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      add_a        = angle_ff;
      add_b        = tmp_ff;
      add_sub      = 1'b0;
      unit_a       = gain0_ff;
      unit_b       = err_ff;
      unit_go      = 1'b0;
      unit_op      = OP_MUL;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               accel_in = req_accel_angle;
               gyro_in  = req_gyro_delta;
               state_in = S_P_MB;
            end
         end
         // prediction
         S_P_MB: begin
            unit_a  = bias_ff;
            unit_b  = dt_ext;
            unit_go = 1'b1;
            if (unit_done) begin
               tmp_in   = unit_result;
               state_in = S_P_SG;
            end
         end
         S_P_SG: begin
            add_a    = gyro_ff;
            add_b    = tmp_ff;
            add_sub  = 1'b1;
            tmp_in   = add_res;
            state_in = S_P_AA;
         end
         S_P_AA: begin
            add_a    = angle_ff;
            add_b    = tmp_ff;
            angle_in = add_res;
            state_in = S_P_D0;
         end
         S_P_D0: begin
            add_a    = qa_ext;
            add_b    = cov_ab_ff;
            add_sub  = 1'b1;
            tmp_in   = add_res;
            state_in = S_P_D1;
         end
         S_P_D1: begin
            add_a    = tmp_ff;
            add_b    = cov_ba_ff;
            add_sub  = 1'b1;
            tmp_in   = add_res;
            state_in = S_P_MD;
         end
         S_P_MD: begin
            unit_a  = tmp_ff;
            unit_b  = dt_ext;
            unit_go = 1'b1;
            if (unit_done) begin
               tmp_in   = unit_result;
               state_in = S_P_CA;
            end
         end
         S_P_CA: begin
            add_a     = cov_aa_ff;
            add_b     = tmp_ff;
            cov_aa_in = add_res;
            state_in  = S_P_NG;
         end
         S_P_NG: begin
            add_a    = '0;
            add_b    = cov_bb_ff;
            add_sub  = 1'b1;
            tmp_in   = add_res;
            state_in = S_P_MN;
         end
         S_P_MN: begin
            unit_a  = tmp_ff;
            unit_b  = dt_ext;
            unit_go = 1'b1;
            if (unit_done) begin
               tmp_in   = unit_result;
               state_in = S_P_CB;
            end
         end
         S_P_CB: begin
            add_a     = cov_ab_ff;
            add_b     = tmp_ff;
            cov_ab_in = add_res;
            state_in  = S_P_CC;
         end
         S_P_CC: begin
            add_a     = cov_ba_ff;
            add_b     = tmp_ff;
            cov_ba_in = add_res;
            state_in  = S_P_MQ;
         end
         S_P_MQ: begin
            unit_a  = qb_ext;
            unit_b  = dt_ext;
            unit_go = 1'b1;
            if (unit_done) begin
               tmp_in   = unit_result;
               state_in = S_P_CD;
            end
         end
         S_P_CD: begin
            add_a     = cov_bb_ff;
            add_b     = tmp_ff;
            cov_bb_in = add_res;
            state_in  = S_U_ER;
         end
         // measurement update
         S_U_ER: begin
            add_a    = accel_ff;
            add_b    = angle_ff;
            add_sub  = 1'b1;
            err_in   = add_res;
            state_in = S_U_E;
         end
         S_U_E: begin
            add_a    = rm_ext;
            add_b    = cov_aa_ff;
            innov_in = add_res;
            state_in = S_U_K0;
         end
         S_U_K0: begin
            if (innov_pos) begin
               unit_a  = cov_aa_ff;
               unit_b  = innov_ff;
               unit_op = OP_DIV;
               unit_go = 1'b1;
               if (unit_done) begin
                  gain0_in = unit_result;
                  state_in = S_U_K1;
               end
            end else begin
               // no usable innovation variance: both gains are zero
               gain0_in = '0;
               gain1_in = '0;
               state_in = S_U_M0;
            end
         end
         S_U_K1: begin
            unit_a  = cov_ba_ff;
            unit_b  = innov_ff;
            unit_op = OP_DIV;
            unit_go = 1'b1;
            if (unit_done) begin
               gain1_in = unit_result;
               state_in = S_U_M0;
            end
         end
         // covariance rows use cov_aa and cov_ab before they are rewritten
         S_U_M0: begin
            unit_a  = gain1_ff;
            unit_b  = cov_aa_ff;
            unit_go = 1'b1;
            if (unit_done) begin
               tmp_in   = unit_result;
               state_in = S_U_S0;
            end
         end
         S_U_S0: begin
            add_a     = cov_ba_ff;
            add_b     = tmp_ff;
            add_sub   = 1'b1;
            cov_ba_in = add_res;
            state_in  = S_U_M1;
         end
         S_U_M1: begin
            unit_a  = gain1_ff;
            unit_b  = cov_ab_ff;
            unit_go = 1'b1;
            if (unit_done) begin
               tmp_in   = unit_result;
               state_in = S_U_S1;
            end
         end
         S_U_S1: begin
            add_a     = cov_bb_ff;
            add_b     = tmp_ff;
            add_sub   = 1'b1;
            cov_bb_in = add_res;
            state_in  = S_U_M2;
         end
         S_U_M2: begin
            unit_a  = gain0_ff;
            unit_b  = cov_ab_ff;
            unit_go = 1'b1;
            if (unit_done) begin
               tmp_in   = unit_result;
               state_in = S_U_S2;
            end
         end
         S_U_S2: begin
            add_a     = cov_ab_ff;
            add_b     = tmp_ff;
            add_sub   = 1'b1;
            cov_ab_in = add_res;
            state_in  = S_U_M3;
         end
         S_U_M3: begin
            unit_a  = gain0_ff;
            unit_b  = cov_aa_ff;
            unit_go = 1'b1;
            if (unit_done) begin
               tmp_in   = unit_result;
               state_in = S_U_S3;
            end
         end
         S_U_S3: begin
            add_a     = cov_aa_ff;
            add_b     = tmp_ff;
            add_sub   = 1'b1;
            cov_aa_in = add_res;
            state_in  = S_U_M4;
         end
         S_U_M4: begin
            unit_a  = gain0_ff;
            unit_b  = err_ff;
            unit_go = 1'b1;
            if (unit_done) begin
               tmp_in   = unit_result;
               state_in = S_U_S4;
            end
         end
         S_U_S4: begin
            add_a    = angle_ff;
            add_b    = tmp_ff;
            angle_in = add_res;
            state_in = S_U_M5;
         end
         S_U_M5: begin
            unit_a  = gain1_ff;
            unit_b  = err_ff;
            unit_go = 1'b1;
            if (unit_done) begin
               tmp_in   = unit_result;
               state_in = S_U_S5;
            end
         end
         S_U_S5: begin
            add_a    = bias_ff;
            add_b    = tmp_ff;
            bias_in  = add_res;
            state_in = S_OUT;
         end
         S_OUT: begin
            add_a   = angle_ff;
            add_b   = zero_offset_ff;
            add_sub = 1'b1;
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = add_res;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         issued_ff        <= 1'b0;
         angle_ff         <= '0;
         bias_ff          <= '0;
         cov_aa_ff        <= COV_ONE;
         cov_ab_ff        <= '0;
         cov_ba_ff        <= '0;
         cov_bb_ff        <= COV_ONE;
         sample_period_ff <= FRAC_BITS'(RST_SAMPLE_PERIOD);
         angle_noise_ff   <= (DATA_WIDTH-1)'(RST_ANGLE_NOISE);
         bias_noise_ff    <= (DATA_WIDTH-1)'(RST_BIAS_NOISE);
         measure_noise_ff <= (DATA_WIDTH-1)'(RST_MEASURE_NOISE);
         zero_offset_ff   <= DATA_WIDTH'(RST_ZERO_OFFSET);
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         issued_ff        <= issued_in;
         angle_ff         <= angle_in;
         bias_ff          <= bias_in;
         cov_aa_ff        <= cov_aa_in;
         cov_ab_ff        <= cov_ab_in;
         cov_ba_ff        <= cov_ba_in;
         cov_bb_ff        <= cov_bb_in;
         sample_period_ff <= sample_period_in;
         angle_noise_ff   <= angle_noise_in;
         bias_noise_ff    <= bias_noise_in;
         measure_noise_ff <= measure_noise_in;
         zero_offset_ff   <= zero_offset_in;
      end
   end

   always_ff @(posedge clock) begin
      accel_ff    <= accel_in;
      gyro_ff     <= gyro_in;
      tmp_ff      <= tmp_in;
      err_ff      <= err_in;
      innov_ff    <= innov_in;
      gain0_ff    <= gain0_in;
      gain1_ff    <= gain1_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tilt_angle = rsp_data_ff;

endmodule

// ===== rtl/core/tkf_checker.sv =====
// port-level checker for the tilt kalman filter and its bind
`include "tilt_kalman_filter_defines.svh"

module tkf_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [DATA_WIDTH-1:0] rsp_tilt_angle
);

   logic       req_fire, rsp_fire;
   logic [1:0] pending_ff, pending_in;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // requests accepted whose response has not yet been taken
   always_comb begin
      pending_in = pending_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `TKF_ASSERT_NEXT(a_busy_after_req, req_fire, !req_ready, "ready stayed high after a request")
   `TKF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_tilt_angle), "response dropped or changed while stalled")
   `TKF_ASSERT_NOW(a_rsp_has_req, rsp_valid, pending_ff != 2'd0, "response without a request")
   `TKF_ASSERT_NOW(a_req_limit, req_fire, pending_ff != 2'd2, "request taken with two outstanding")

endmodule

bind tilt_kalman_filter tkf_checker #(.DATA_WIDTH(DATA_WIDTH)) u_tkf_checker (.*);

// ===== sim/tilt_kalman_checker.sv =====
// response checker for the tilt kalman filter: predicts each filtered angle and compares it
`timescale 1ns / 100ps
module tilt_kalman_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [31:0]                req_accel_angle,
   input  logic signed [31:0]                req_gyro_delta,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [31:0]                rsp_tilt_angle,
   input  logic                              csr_wr_en,
   input  logic [tkf_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [31:0]                       csr_wdata,
   output int                                angles_pending,
   output int                                mismatch_count
);
   import tkf_pkg::*;

   typedef longint unsigned mag_type;

   localparam int     FRAC     = 28;
   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;
   localparam longint Q_ONE    = longint'(1) << FRAC;

   // register copies
   longint step_dt, angle_noise, bias_noise, meas_noise, zero_ofs;
   // filter state
   longint angle_est, bias_est, p_aa, p_ab, p_ba, p_bb;

   logic signed [31:0] tilt_expected_q[$];
   logic signed [31:0] tilt_want;
   int                 miss_total = 0;

   function automatic longint clamp_word(longint x);
      if (x > WORD_MAX) return WORD_MAX;
      if (x < WORD_MIN) return WORD_MIN;
      return x;
   endfunction

   function automatic longint add_sat(longint a, longint b);
      return clamp_word(a + b);
   endfunction

   function automatic longint sub_sat(longint a, longint b);
      return clamp_word(a - b);
   endfunction

   function automatic mag_type magnitude(longint x);
      if (x < 0) return -x;
      return x;
   endfunction

   function automatic longint signed_limit(bit neg, mag_type m);
      if (neg) return (m > 64'd2147483648) ? WORD_MIN : -longint'(m);
      return (m > 64'd2147483647) ? WORD_MAX : longint'(m);
   endfunction

   // exact product, truncated toward zero after dropping the fraction bits
   function automatic longint q_mul(longint a, longint b);
      mag_type prod;
      prod = magnitude(a) * magnitude(b);
      return signed_limit((a < 0) != (b < 0), prod >> FRAC);
   endfunction

   // (n << FRAC) / d with d positive, truncated toward zero
   function automatic longint q_div(longint n, longint d);
      mag_type num, den;
      num = magnitude(n) << FRAC;
      den = d;
      return signed_limit(n < 0, num / den);
   endfunction

   function automatic logic signed [31:0] filter_step(longint accel, longint gyro);
      longint d0, dneg, err, pct0, pct1, innov, k0, k1, t1;
      k0 = 0;
      k1 = 0;
      // predict
      angle_est = add_sat(angle_est, sub_sat(gyro, q_mul(bias_est, step_dt)));
      d0 = sub_sat(sub_sat(angle_noise, p_ab), p_ba);
      dneg = clamp_word(-p_bb);
      p_aa = add_sat(p_aa, q_mul(d0, step_dt));
      p_ab = add_sat(p_ab, q_mul(dneg, step_dt));
      p_ba = add_sat(p_ba, q_mul(dneg, step_dt));
      p_bb = add_sat(p_bb, q_mul(bias_noise, step_dt));
      // correct
      err = sub_sat(accel, angle_est);
      pct0 = p_aa;
      pct1 = p_ba;
      innov = add_sat(meas_noise, pct0);
      // gains stay zero when the innovation variance is not positive
      if (innov > 0) begin
         k0 = q_div(pct0, innov);
         k1 = q_div(pct1, innov);
      end
      t1 = p_ab;
      p_aa = sub_sat(p_aa, q_mul(k0, pct0));
      p_ab = sub_sat(p_ab, q_mul(k0, t1));
      p_ba = sub_sat(p_ba, q_mul(k1, pct0));
      p_bb = sub_sat(p_bb, q_mul(k1, t1));
      angle_est = add_sat(angle_est, q_mul(k0, err));
      bias_est = add_sat(bias_est, q_mul(k1, err));
      return 32'(clamp_word(angle_est - zero_ofs));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         step_dt = longint'(RST_SAMPLE_PERIOD);
         angle_noise = longint'(RST_ANGLE_NOISE);
         bias_noise = longint'(RST_BIAS_NOISE);
         meas_noise = longint'(RST_MEASURE_NOISE);
         zero_ofs = longint'(RST_ZERO_OFFSET);
         angle_est = 0;
         bias_est = 0;
         p_aa = Q_ONE;
         p_ab = 0;
         p_ba = 0;
         p_bb = Q_ONE;
         tilt_expected_q.delete();
         angles_pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (tilt_expected_q.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %0d",
                        $time, rsp_tilt_angle);
               miss_total++;
            end else begin
               tilt_want = tilt_expected_q.pop_front();
               if (rsp_tilt_angle !== tilt_want) begin
                  $display("%0t: tilt_angle mismatch, expected %0d actual %0d",
                           $time, tilt_want, rsp_tilt_angle);
                  miss_total++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SAMPLE_PERIOD: step_dt = longint'(csr_wdata[FRAC-1:0]);
               CSR_ANGLE_NOISE:   angle_noise = longint'(csr_wdata[30:0]);
               CSR_BIAS_NOISE:    bias_noise = longint'(csr_wdata[30:0]);
               CSR_MEASURE_NOISE: meas_noise = longint'(csr_wdata[30:0]);
               CSR_ZERO_OFFSET:   zero_ofs = longint'($signed(csr_wdata));
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            tilt_expected_q.push_back(filter_step(longint'(req_accel_angle),
                                                  longint'(req_gyro_delta)));
         angles_pending <= tilt_expected_q.size();
      end
      mismatch_count <= miss_total;
   end

endmodule

// ===== sim/tb.sv =====
// testbench top for the tilt kalman filter: stimulus, handshake pacing and verdict
`timescale 1ns / 100ps
module tb;
   import tkf_pkg::*;

   localparam int DATA_WIDTH    = 32;
   localparam int FRAC_BITS     = 28;
   localparam int TILT_REQUESTS = 1450;
   localparam int CYCLE_LIMIT   = 1_600_000;
   localparam int SETTLE_CYCLES = 250;
   localparam int ONE_RAD       = 1 << FRAC_BITS;
   localparam int TILT_BOUND    = 429_496_729;   // about 1.6 rad
   localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] WORD_MIN = 32'sh80000000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [31:0]       req_accel_angle = '0;
   logic signed [31:0]       req_gyro_delta = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [31:0]       rsp_tilt_angle;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = CSR_SAMPLE_PERIOD;
   logic [31:0]              csr_wdata = '0;

   int  angles_pending;
   int  mismatch_count;
   int  cycle_count = 0;
   int  sent_count = 0;
   bit  tx_steady = 1'b0;
   bit  rx_steady = 1'b0;
   int  true_tilt = 0;
   int  gyro_drift = 0;
   logic signed [31:0] corners [4] = '{WORD_MAX, WORD_MIN, 32'sd0, -32'sd1};

   always #5 clock = ~clock;

   tilt_kalman_filter #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_accel_angle(req_accel_angle),
      .req_gyro_delta (req_gyro_delta),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tilt_angle (rsp_tilt_angle),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   tilt_kalman_checker tilt_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_accel_angle(req_accel_angle),
      .req_gyro_delta (req_gyro_delta),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tilt_angle (rsp_tilt_angle),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .angles_pending (angles_pending),
      .mismatch_count (mismatch_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tilt_kalman_filter test failed");
         $finish;
      end
   end

   // response side back-pressure
   initial begin : response_pacing
      int stall;
      forever begin
         stall = rx_steady ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   task automatic send_tilt(input logic signed [31:0] accel, input logic signed [31:0] gyro);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_accel_angle <= accel;
      req_gyro_delta <= gyro;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // hold off new requests until every predicted angle has come back
   task automatic drain_requests();
      req_valid <= 1'b0;
      @(posedge clock);
      while (angles_pending != 0) @(posedge clock);
   endtask

   task automatic write_settings(input logic [31:0] period, input logic [31:0] angle_noise,
                                 input logic [31:0] bias_noise, input logic [31:0] meas_noise,
                                 input logic [31:0] zero_ofs);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SAMPLE_PERIOD;
      csr_wdata <= period;
      @(posedge clock);
      csr_index <= CSR_ANGLE_NOISE;
      csr_wdata <= angle_noise;
      @(posedge clock);
      csr_index <= CSR_BIAS_NOISE;
      csr_wdata <= bias_noise;
      @(posedge clock);
      csr_index <= CSR_MEASURE_NOISE;
      csr_wdata <= meas_noise;
      @(posedge clock);
      csr_index <= CSR_ZERO_OFFSET;
      csr_wdata <= zero_ofs;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // plausible motion: smooth tilt walk, gyro sees the step plus a drift,
   // accelerometer sees the tilt plus noise
   task automatic send_motion();
      int step, noise;
      step = int'($urandom_range(0, 10_737_418)) - 5_368_709;
      noise = int'($urandom_range(0, 26_843_546)) - 13_421_773;
      true_tilt += step;
      if (true_tilt > TILT_BOUND || true_tilt < -TILT_BOUND) begin
         true_tilt -= 2 * step;
         step = -step;
      end
      send_tilt(true_tilt + noise, step + gyro_drift);
   endtask

   initial begin : stimulus
      int phase, burst;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // field extremes and small values at the reset settings
      send_tilt(0, 0);
      send_tilt(WORD_MAX, 0);
      send_tilt(WORD_MIN, 0);
      send_tilt(0, WORD_MAX);
      send_tilt(0, WORD_MIN);
      send_tilt(WORD_MAX, WORD_MAX);
      send_tilt(WORD_MIN, WORD_MIN);
      send_tilt(WORD_MAX, WORD_MIN);
      send_tilt(WORD_MIN, WORD_MAX);
      send_tilt(-1, 1);
      send_tilt(ONE_RAD / 2, ONE_RAD / 100);
      send_tilt(-ONE_RAD / 4, -ONE_RAD / 50);

      // zero time step and zero measurement noise: covariance collapses,
      // then the innovation variance is no longer positive
      drain_requests();
      write_settings(0, RST_ANGLE_NOISE[31:0], RST_BIAS_NOISE[31:0], 0, RST_ZERO_OFFSET[31:0]);
      repeat (4) send_motion();
      drain_requests();

      phase = 0;
      while (sent_count < TILT_REQUESTS) begin
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         gyro_drift = int'($urandom_range(0, 2_684_354)) - 1_342_177;
         case (phase % 8)
            0: write_settings(RST_SAMPLE_PERIOD[31:0], RST_ANGLE_NOISE[31:0],
                              RST_BIAS_NOISE[31:0], RST_MEASURE_NOISE[31:0],
                              RST_ZERO_OFFSET[31:0]);
            2: write_settings(1, 0, 0, 1, WORD_MIN);
            3: write_settings(32'h0fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, WORD_MAX);
            4: write_settings($urandom, $urandom, $urandom, $urandom, $urandom);
            6: write_settings(0, $urandom_range(0, 2_684_354), $urandom_range(0, 2_684_354),
                              $urandom_range(1, 536_870_912),
                              int'($urandom_range(0, 26_843_546)) - 13_421_773);
            default: write_settings($urandom_range(268_435, 26_843_545),
                                    $urandom_range(0, 2_684_354),
                                    $urandom_range(0, 2_684_354),
                                    $urandom_range(1, 536_870_912),
                                    int'($urandom_range(0, 26_843_546)) - 13_421_773);
         endcase
         burst = $urandom_range(30, 110);
         repeat (burst) begin
            case ($urandom_range(0, 9))
               8: send_tilt($urandom, $urandom);
               9: send_tilt(corners[2'($urandom_range(0, 3))],
                            corners[2'($urandom_range(0, 3))]);
               default: send_motion();
            endcase
         end
         drain_requests();
         phase++;
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tilt_kalman_filter test passed");
      else
         $display("tilt_kalman_filter test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tkf_pkg.sv
rtl/core/tkf_muldiv.sv
rtl/core/tilt_kalman_filter.sv
rtl/core/tkf_checker.sv
sim/tilt_kalman_checker.sv
sim/tb.sv
